>>> sv/vsc_pkg.sv
// vsc_pkg: shared types, register indexes and command codes for the vigenere stream cipher
// no dependencies; imported by every module of the block

package vsc_pkg;

	localparam int ALPHABET_MAX_DEF = 32;
	localparam int KEY_MAX_DEF      = 16;

	localparam int ALPHA_CHARS = 32;
	localparam int KEY_CHARS   = 16;
	localparam int KI_W        = $clog2(KEY_CHARS);
	localparam int CHAR_W      = 8;
	localparam int ASIZE_W     = 6;
	localparam int KLEN_W      = 5;
	localparam int DATA_W      = 64;
	localparam int ADDR_W      = 6;
	localparam int REG_IDX_W   = 3;

	localparam logic [REG_IDX_W-1:0] REG_ALPHA_LOW   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA_MID   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA_UPPER = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA_TOP   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA_SIZE  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_KEY_LOW     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH    = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_KEY_LEN     = 3'd7;

	localparam logic [ASIZE_W-1:0] ALPHA_SIZE_RST = 6'd26;
	localparam logic [KLEN_W-1:0]  KEY_LEN_RST    = 5'd1;

	localparam logic [1:0] CMD_ENC  = 2'd0;
	localparam logic [1:0] CMD_DEC  = 2'd1;
	localparam logic [1:0] CMD_AUTO = 2'd2;
	localparam logic [1:0] CMD_RSVD = 2'd3;

	typedef struct packed {
		logic [1:0]        cmd;
		logic              message_start;
		logic [CHAR_W-1:0] in_char;
	} in_beat_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              passed_through;
	} out_beat_t;

	typedef struct packed {
		logic [ALPHA_CHARS-1:0][CHAR_W-1:0] alpha;
		logic [ASIZE_W-1:0]                 alpha_size;
		logic [KEY_CHARS-1:0][CHAR_W-1:0]   key;
		logic [KLEN_W-1:0]                  key_length;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [CHAR_W-1:0] in_char;
		logic [CHAR_W-1:0] key_char;
	} xf_req_t;

endpackage

>>> sv/vsc_cfg_regs.sv
// vsc_cfg_regs: apb register file holding alphabet, alphabet size, key and key length
// depends on vsc_pkg

module vsc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vsc_pkg::ADDR_W-1:0]  paddr,
	input  logic [vsc_pkg::DATA_W-1:0]  pwdata,
	output logic [vsc_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output vsc_pkg::cfg_t               cfg
);
	import vsc_pkg::*;

	logic [DATA_W-1:0]    alpha_low_q, alpha_mid_q, alpha_upper_q, alpha_top_q;
	logic [DATA_W-1:0]    key_low_q, key_high_q;
	logic [ASIZE_W-1:0]   alpha_size_q;
	logic [KLEN_W-1:0]    key_len_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_low_q   <= '0;
			alpha_mid_q   <= '0;
			alpha_upper_q <= '0;
			alpha_top_q   <= '0;
			alpha_size_q  <= ALPHA_SIZE_RST;
			key_low_q     <= '0;
			key_high_q    <= '0;
			key_len_q     <= KEY_LEN_RST;
		end else if (wr) begin
			unique case (idx)
				REG_ALPHA_LOW:   alpha_low_q   <= pwdata;
				REG_ALPHA_MID:   alpha_mid_q   <= pwdata;
				REG_ALPHA_UPPER: alpha_upper_q <= pwdata;
				REG_ALPHA_TOP:   alpha_top_q   <= pwdata;
				REG_ALPHA_SIZE:  alpha_size_q  <= pwdata[ASIZE_W-1:0];
				REG_KEY_LOW:     key_low_q     <= pwdata;
				REG_KEY_HIGH:    key_high_q    <= pwdata;
				REG_KEY_LEN:     key_len_q     <= pwdata[KLEN_W-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ALPHA_LOW:   prdata = alpha_low_q;
			REG_ALPHA_MID:   prdata = alpha_mid_q;
			REG_ALPHA_UPPER: prdata = alpha_upper_q;
			REG_ALPHA_TOP:   prdata = alpha_top_q;
			REG_ALPHA_SIZE:  prdata = DATA_W'(alpha_size_q);
			REG_KEY_LOW:     prdata = key_low_q;
			REG_KEY_HIGH:    prdata = key_high_q;
			REG_KEY_LEN:     prdata = DATA_W'(key_len_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.alpha      = {alpha_top_q, alpha_upper_q, alpha_mid_q, alpha_low_q};
	assign cfg.alpha_size = alpha_size_q;
	assign cfg.key        = {key_high_q, key_low_q};
	assign cfg.key_length = key_len_q;

endmodule

>>> sv/vsc_key_sched.sv
// vsc_key_sched: input register, key position and history pointer, plaintext history memory
// depends on vsc_pkg; feeds vsc_xform with the character and its key character

module vsc_key_sched #(
	parameter int KEY_MAX = vsc_pkg::KEY_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vsc_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  vsc_pkg::in_beat_t in_data,
	output logic              req_valid,
	input  logic              req_ready,
	output vsc_pkg::xf_req_t  req
);
	import vsc_pkg::*;

	localparam int KL_CAP = (KEY_MAX < KEY_CHARS) ? KEY_MAX : KEY_CHARS;
	localparam int HP_W   = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int SW     = ((HP_W > KLEN_W) ? HP_W : KLEN_W) + 2;

	logic [KLEN_W-1:0] kp_q;
	logic [HP_W-1:0]   hp_q;
	logic              s1_valid_q;

	logic [1:0]        cmd_s1;
	logic [CHAR_W-1:0] char_s1;
	logic [CHAR_W-1:0] kchar_s1;
	logic [CHAR_W-1:0] hist_rd_s1;
	logic              use_hist_s1;

	logic [CHAR_W-1:0] hist_mem [KEY_MAX];

	logic              accept;
	logic [KLEN_W-1:0] kl, kp0, ki, kp_nx;
	logic [HP_W-1:0]   hp0, hp_nx, rd_slot;
	logic [SW-1:0]     slot_sum;
	logic [KI_W-1:0]   key_idx;
	logic              use_hist;

	assign in_ready = !s1_valid_q || req_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (cfg.key_length == '0)
			kl = KLEN_W'(1);
		else if (cfg.key_length > KLEN_W'(KL_CAP))
			kl = KLEN_W'(KL_CAP);
		else
			kl = cfg.key_length;
	end

	// message start clears position and pointer before this beat is used
	always_comb begin
		kp0      = in_data.message_start ? '0 : kp_q;
		hp0      = in_data.message_start ? '0 : hp_q;
		use_hist = 1'b0;
		key_idx  = '0;
		ki       = '0;
		kp_nx    = kp0;
		if (in_data.cmd == CMD_AUTO) begin
			if (kp0 < kl) begin
				key_idx = kp0[KI_W-1:0];
				kp_nx   = kp0 + KLEN_W'(1);
			end else begin
				use_hist = 1'b1;
				kp_nx    = kl;
			end
		end else begin
			ki      = (kp0 >= kl) ? '0 : kp0;
			key_idx = ki[KI_W-1:0];
			kp_nx   = ((ki + KLEN_W'(1)) >= kl) ? '0 : ki + KLEN_W'(1);
		end
	end

	always_comb begin
		hp_nx    = (hp0 == HP_W'(KEY_MAX - 1)) ? '0 : hp0 + HP_W'(1);
		slot_sum = SW'(hp0) + SW'(KEY_MAX) - SW'(kl);
		if (slot_sum >= SW'(KEY_MAX))
			slot_sum = slot_sum - SW'(KEY_MAX);
		rd_slot  = slot_sum[HP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q       <= '0;
			hp_q       <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				kp_q       <= kp_nx;
				hp_q       <= hp_nx;
				s1_valid_q <= 1'b1;
			end else if (req_ready) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// history read sees the slot before this beat's write
	always_ff @(posedge clk) begin
		if (accept) begin
			hist_mem[hp0] <= in_data.in_char;
			hist_rd_s1    <= hist_mem[rd_slot];
			cmd_s1        <= in_data.cmd;
			char_s1       <= in_data.in_char;
			kchar_s1      <= cfg.key[key_idx];
			use_hist_s1   <= use_hist;
		end
	end

	assign req_valid    = s1_valid_q;
	assign req.cmd      = cmd_s1;
	assign req.in_char  = char_s1;
	assign req.key_char = use_hist_s1 ? hist_rd_s1 : kchar_s1;

endmodule

>>> sv/vsc_xform.sv
// vsc_xform: alphabet lookup of character and key character, modular add or subtract, result register
// depends on vsc_pkg

module vsc_xform #(
	parameter int ALPHABET_MAX = vsc_pkg::ALPHABET_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vsc_pkg::cfg_t      cfg,
	input  logic               req_valid,
	output logic               req_ready,
	input  vsc_pkg::xf_req_t   req,
	output logic               out_valid,
	input  logic               out_ready,
	output vsc_pkg::out_beat_t out_data
);
	import vsc_pkg::*;

	localparam int A_LANES = (ALPHABET_MAX < ALPHA_CHARS) ? ALPHABET_MAX : ALPHA_CHARS;
	localparam int IW      = $clog2(A_LANES);
	localparam int NW      = IW + 1;

	logic               out_valid_q;
	out_beat_t          out_data_q;
	out_beat_t          res;
	logic [NW-1:0]      n;
	logic [NW:0]        a_find, b_find;
	logic [NW-1:0]      a, b, pos;
	logic               hit;

	// lowest matching index wins; top bit flags a hit
	function automatic logic [NW:0] find_idx(
		input logic [CHAR_W-1:0]                 c,
		input logic [ALPHA_CHARS-1:0][CHAR_W-1:0] alpha,
		input logic [NW-1:0]                     len
	);
		logic [NW:0] r;
		r = '0;
		for (int i = A_LANES - 1; i >= 0; i--) begin
			if ((NW'(i) < len) && (alpha[i] == c))
				r = {1'b1, NW'(i)};
		end
		return r;
	endfunction

	always_comb begin
		if (cfg.alpha_size > ASIZE_W'(A_LANES))
			n = NW'(A_LANES);
		else
			n = NW'(cfg.alpha_size);
		a_find = find_idx(req.in_char, cfg.alpha, n);
		b_find = find_idx(req.key_char, cfg.alpha, n);
		a      = a_find[NW-1:0];
		b      = b_find[NW-1:0];
		hit    = a_find[NW] && b_find[NW];
		pos    = '0;
		res.out_char       = req.in_char;
		res.passed_through = 1'b1;
		unique case (req.cmd)
			CMD_ENC, CMD_AUTO: begin
				pos = a + b;
				if (pos >= n)
					pos = pos - n;
			end
			CMD_DEC: begin
				pos = (a >= b) ? a - b : a + n - b;
			end
			CMD_RSVD: pos = '0;
			default:  pos = '0;
		endcase
		if (hit && (req.cmd != CMD_RSVD)) begin
			res.out_char       = cfg.alpha[pos[IW-1:0]];
			res.passed_through = 1'b0;
		end
	end

	assign req_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req_ready) begin
			out_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			out_data_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> sv/vigenere_stream_cipher_top.sv
// channel  | dir | handshake               | beat
// in       | in  | in_valid / in_ready     | in_data  (cmd, message_start, in_char)
// out      | out | out_valid / out_ready   | out_data (out_char, passed_through)
// cfg      | in  | apb psel/penable/pready | paddr, pwdata, prdata (64-bit, reg i at 8*i)
//
// one beat per cycle sustained unless out_ready stalls the output
// input register: key position, history pointer and plaintext history memory read/write
// after it: parallel alphabet compare, modular add or subtract, into the result register
// arst_n clears position, pointer and valid flags; history memory has no reset
// a stalled output holds its beat while one more beat waits in the input register

module vigenere_stream_cipher_top #(
	parameter int ALPHABET_MAX = vsc_pkg::ALPHABET_MAX_DEF,
	parameter int KEY_MAX      = vsc_pkg::KEY_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  vsc_pkg::in_beat_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output vsc_pkg::out_beat_t         out_data,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [vsc_pkg::ADDR_W-1:0] paddr,
	input  logic [vsc_pkg::DATA_W-1:0] pwdata,
	output logic [vsc_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import vsc_pkg::*;

	cfg_t    cfg;
	xf_req_t req;
	logic    req_valid, req_ready;

	vsc_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vsc_key_sched #(
		.KEY_MAX (KEY_MAX)
	) u_key_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req)
	);

	vsc_xform #(
		.ALPHABET_MAX (ALPHABET_MAX)
	) u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> sv/vsc_checker.sv
// vsc_checker: port-level checks on the vigenere stream cipher top level
// depends on vsc_pkg; bound to vigenere_stream_cipher_top at the end of this file

module vsc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input vsc_pkg::in_beat_t          in_data,
	input logic                       out_valid,
	input logic                       out_ready,
	input vsc_pkg::out_beat_t         out_data,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [vsc_pkg::ADDR_W-1:0] paddr,
	input logic [vsc_pkg::DATA_W-1:0] pwdata,
	input logic [vsc_pkg::DATA_W-1:0] prdata,
	input logic                       pready
);
	import vsc_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// nothing comes out straight after reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid straight after reset");

	// a free output side never blocks the input side
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled with output ready");

	// unused command passes the character through to the output when the output side does not stall it
	a_rsvd_pass: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.cmd == CMD_RSVD) ##1 (!out_valid || out_ready)
		|=> out_valid && out_data.passed_through
			&& (out_data.out_char == $past(in_data.in_char, 2)))
		else $error("unused command not passed through");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready && !(psel && penable && pwrite && (prdata === 'x)))
		else $error("apb port not ready");

endmodule

bind vigenere_stream_cipher_top vsc_checker u_vsc_checker (.*);
